### sv/vnu_pkg.sv
// vnu_pkg: shared types and constants of the vector normalize unit
// no dependencies; used by vnu_div, vec3_normalize_unit and tb_top
package vnu_pkg;

    // default number of fraction bits of the unit components
    localparam int OUT_FRAC_BITS = 30;

    localparam int COMP_W = 32;
    localparam int SQ_W   = 64;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic        [COMP_W-1:0] length;
        logic                     zero_vector;
    } out_t;

endpackage

### sv/vnu_isqrt.sv
// vnu_isqrt: pipelined integer square root, one result bit per stage
// depends on nothing; sideband bits travel along with each request
module vnu_isqrt #(
    parameter int W      = 64,
    parameter int SIDE_W = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [W-1:0]          in_n,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [(W+1)/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);
    localparam int STG = (W + 1) / 2;
    localparam int NW  = 2 * STG;

    logic [NW-1:0]     n_reg    [STG];
    logic [NW-1:0]     root_reg [STG];
    logic [SIDE_W-1:0] side_reg [STG];
    logic [STG-1:0]    valid_reg;

    for (genvar i = 0; i < STG; i++) begin : g_stage
        localparam logic [NW-1:0] BITV = {{(NW-1){1'b0}}, 1'b1} << (2 * (STG - 1 - i));
        logic [NW-1:0] n_in;
        logic [NW-1:0] root_in;
        logic [NW-1:0] n_next;
        logic [NW-1:0] root_next;
        logic [NW:0]   trial;
        logic          ge;
        logic          v_in;
        logic [SIDE_W-1:0] s_in;

        if (i == 0) begin : g_first
            assign n_in    = NW'(in_n);
            assign root_in = '0;
            assign v_in    = in_valid;
            assign s_in    = in_side;
        end else begin : g_next
            assign n_in    = n_reg[i-1];
            assign root_in = root_reg[i-1];
            assign v_in    = valid_reg[i-1];
            assign s_in    = side_reg[i-1];
        end

        always_comb begin
            trial     = {1'b0, root_in} + {1'b0, BITV};
            ge        = {1'b0, n_in} >= trial;
            n_next    = ge ? (n_in - trial[NW-1:0]) : n_in;
            root_next = ge ? ((root_in >> 1) + BITV) : (root_in >> 1);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i]    <= n_next;
                root_reg[i] <= root_next;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[STG-1];
    assign out_root  = root_reg[STG-1][STG-1:0];
    assign out_side  = side_reg[STG-1];

endmodule

### sv/vnu_div.sv
// vnu_div: pipelined restoring divider, floor(num * 2^(QW-1) / den), one bit per stage
// needs num <= den for a meaningful quotient; uses vnu_pkg widths
module vnu_div #(
    parameter int QW     = 61,
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [vnu_pkg::SQ_W-1:0]   in_num,
    input  logic [vnu_pkg::SQ_W-1:0]   in_den,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [QW-1:0]              out_quo,
    output logic [SIDE_W-1:0]          out_side
);
    localparam int DW = vnu_pkg::SQ_W;

    logic [DW-1:0]     rem_reg  [QW];
    logic [DW-1:0]     den_reg  [QW];
    logic [QW-1:0]     quo_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];
    logic [QW-1:0]     valid_reg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   trial;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          qbit;
        logic          v_in;
        logic [SIDE_W-1:0] s_in;
        logic [DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign trial  = {1'b0, in_num};
            assign den_in = in_den;
            assign quo_in = '0;
            assign v_in   = in_valid;
            assign s_in   = in_side;
        end else begin : g_next
            assign trial  = {rem_reg[k-1], 1'b0};
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign v_in   = valid_reg[k-1];
            assign s_in   = side_reg[k-1];
        end

        always_comb begin
            qbit     = trial >= {1'b0, den_in};
            rem_next = qbit ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= {quo_in[QW-2:0], qbit};
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

### sv/vec3_normalize_unit.sv
// vec3_normalize_unit: top level of the 3-vector normalize pipeline
// depends on vnu_pkg, vnu_isqrt and vnu_div
//
// usage
//   s_valid/s_ready/s_data carry one request: a vector of three signed
//   Q16.16 components. m_valid/m_ready/m_data return one result per request:
//   the unit vector in signed Q1.OUT_FRAC_BITS, the magnitude floor(sqrt(S))
//   in Q16.16 and a zero_vector flag (all other fields zero when set).
//   throughput: one request per cycle while the pipeline is not stalled
//   path: the magnitude, square and sum stages, then the bit-per-stage
//   length square root chain, the per-lane divider and unit square root
//   chains and finally the output register
//   a unit component is isqrt(floor(c^2 * 2^(2F) / S)), which equals the
//   exact truncated quotient |c| * 2^F / sqrt(S)
//   stall: the whole pipeline holds while the output register is full and
//   m_ready is low; s_ready follows that, nothing is dropped or repeated
//   reset: aresetn (synchronous, active low) clears every valid bit; the
//   data registers are not reset
module vec3_normalize_unit #(
    parameter int OUT_FRAC_BITS = vnu_pkg::OUT_FRAC_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  vnu_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output vnu_pkg::out_t   m_data
);
    localparam int CW  = vnu_pkg::COMP_W;
    localparam int SW  = vnu_pkg::SQ_W;
    localparam int QW  = 2 * OUT_FRAC_BITS + 1;   // quotient width
    localparam int UW  = (QW + 1) / 2;            // unit magnitude width
    localparam int LW  = SW / 2;                  // length width
    // sideband of the length root: three squares, sum, zero flag, signs
    localparam int LS_W = 4 * SW + 4;
    localparam int XS_W = LW + 2;                 // length, zero, sign

    // global advance: the output register is empty or being drained
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 0: component magnitudes and signs
    logic          v0_reg;
    logic [CW-1:0] mag_reg [3];
    logic [2:0]    neg0_reg;
    logic [CW-1:0] raw [3];

    assign raw[0] = s_data.comp_x;
    assign raw[1] = s_data.comp_y;
    assign raw[2] = s_data.comp_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // the most negative value maps to 2^31, still fits unsigned
                mag_reg[i]  <= raw[i][CW-1] ? (~raw[i] + CW'(1)) : raw[i];
                neg0_reg[i] <= raw[i][CW-1];
            end
        end
    end

    // stage 1: squares, one 32x32 multiplier per lane
    logic          v1_reg;
    logic [SW-1:0] sq_reg [3];
    logic [2:0]    neg1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= SW'(mag_reg[i]) * SW'(mag_reg[i]);
            end
            neg1_reg <= neg0_reg;
        end
    end

    // stage 2: sum of squares, below 2^64 since each square is at most 2^62
    logic          v2_reg;
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sq2_reg [3];
    logic [2:0]    neg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq2_reg  <= sq_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // length root; the rest of the request rides along as sideband
    logic            lv;
    logic [LW-1:0]   len_root;
    logic [LS_W-1:0] ls_in;
    logic [LS_W-1:0] ls_out;

    assign ls_in = {sq2_reg[0], sq2_reg[1], sq2_reg[2], sum_reg,
                    (sum_reg == '0), neg2_reg};

    vnu_isqrt #(.W(SW), .SIDE_W(LS_W)) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_n      (sum_reg),
        .in_side   (ls_in),
        .out_valid (lv),
        .out_root  (len_root),
        .out_side  (ls_out)
    );

    logic [SW-1:0] l_sq [3];
    logic [SW-1:0] l_sum;
    logic          l_zero;
    logic [2:0]    l_neg;

    assign {l_sq[0], l_sq[1], l_sq[2], l_sum, l_zero, l_neg} = ls_out;

    // per-lane divide and root; lane x also carries length and zero flag
    logic          lane_v   [3];
    logic [UW-1:0] lane_q   [3];
    logic [2:0]    lane_neg;
    logic [LW-1:0] fin_len;
    logic          fin_zero;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        localparam int SD_W = (i == 0) ? XS_W : 1;
        logic            dv;
        logic [QW-1:0]   quo;
        logic [SD_W-1:0] d_side_in;
        logic [SD_W-1:0] d_side_out;
        logic [SD_W-1:0] r_side_out;

        if (i == 0) begin : g_x
            assign d_side_in = {len_root, l_zero, l_neg[0]};
            assign {fin_len, fin_zero, lane_neg[i]} = r_side_out;
        end else begin : g_yz
            assign d_side_in   = l_neg[i];
            assign lane_neg[i] = r_side_out[0];
        end

        vnu_div #(.QW(QW), .SIDE_W(SD_W)) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (lv),
            .in_num    (l_sq[i]),
            .in_den    (l_sum),
            .in_side   (d_side_in),
            .out_valid (dv),
            .out_quo   (quo),
            .out_side  (d_side_out)
        );

        vnu_isqrt #(.W(QW), .SIDE_W(SD_W)) u_unit_sqrt (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv),
            .in_n      (quo),
            .in_side   (d_side_out),
            .out_valid (lane_v[i]),
            .out_root  (lane_q[i]),
            .out_side  (r_side_out)
        );
    end

    // output register: sign restore and zero-vector override
    logic          m_valid_reg;
    vnu_pkg::out_t m_data_reg;
    logic [CW-1:0] unit_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unit_next[i] = lane_neg[i] ? (~CW'(lane_q[i]) + CW'(1)) : CW'(lane_q[i]);
            if (fin_zero) begin
                unit_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= lane_v[0] && lane_v[1] && lane_v[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.unit_x      <= unit_next[0];
            m_data_reg.unit_y      <= unit_next[1];
            m_data_reg.unit_z      <= unit_next[2];
            m_data_reg.length      <= fin_len;
            m_data_reg.zero_vector <= fin_zero;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // the three lanes stay in lockstep
    a_lane_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_v[0] == lane_v[1]) && (lane_v[1] == lane_v[2]))
        else $error("lane valid bits disagree");

    // a zero vector gives all-zero components and length
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_vector |-> (m_data.unit_x == '0) &&
        (m_data.unit_y == '0) && (m_data.unit_z == '0) && (m_data.length == '0))
        else $error("zero vector with nonzero fields");

    // a unit magnitude never exceeds one
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_v[0] && !fin_zero |-> (lane_q[0] <= (UW'(1) << OUT_FRAC_BITS)) &&
        (lane_q[1] <= (UW'(1) << OUT_FRAC_BITS)) &&
        (lane_q[2] <= (UW'(1) << OUT_FRAC_BITS)))
        else $error("unit component above one");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for vec3_normalize_unit, directed table then random vectors
// depends on vnu_pkg and vec3_normalize_unit; predictor computes exact magnitude and unit
module tb_top;

    localparam int FRAC      = vnu_pkg::OUT_FRAC_BITS;
    localparam int N_RANDOM  = 1700;
    localparam int LATENCY   = 128;
    localparam int MAX_CYCLE = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vnu_pkg::in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vnu_pkg::out_t m_data;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    vec3_normalize_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // one row of the directed table; known marks a hand-typed result
    typedef struct {
        vnu_pkg::in_t  vec;
        logic          known;
        vnu_pkg::out_t res;
    } vec_row_t;

    vnu_pkg::out_t pending_units[$];
    vec_row_t vec_table[$];
    int     errors = 0;
    int     results_seen = 0;
    int     zero_seen = 0;
    longint cycle = 0;
    logic   feed_done = 1'b0;

    // magnitude of a 32-bit two's complement component, 0..2^31
    function automatic logic [32:0] comp_mag(logic signed [31:0] c);
        return c[31] ? (33'd0 - {c[31], c}) : {1'b0, c};
    endfunction

    // floor(sqrt(n)) by bit-by-bit search
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= n) r = t;
        end
        return r;
    endfunction

    // floor(a * 2^FRAC / sqrt(s)), found as largest q with q^2 * s <= a^2 * 2^(2*FRAC)
    function automatic logic [31:0] unit_part(logic [32:0] a, logic [63:0] s);
        logic [191:0] rhs;
        logic [191:0] lhs;
        logic [31:0]  q;
        logic [31:0]  t;
        rhs = ({159'd0, a} * {159'd0, a}) << (2 * FRAC);
        q = '0;
        for (int b = FRAC; b >= 0; b--) begin
            t = q | (32'd1 << b);
            lhs = {160'd0, t} * {160'd0, t} * {128'd0, s};
            if (lhs <= rhs) q = t;
        end
        return q;
    endfunction

    function automatic vnu_pkg::out_t normalize_vec(vnu_pkg::in_t v);
        vnu_pkg::out_t r;
        logic [32:0] mx, my, mz;
        logic [63:0] sum_sq;
        logic [31:0] q;
        mx = comp_mag(v.comp_x);
        my = comp_mag(v.comp_y);
        mz = comp_mag(v.comp_z);
        sum_sq = ({31'd0, mx} * {31'd0, mx}) + ({31'd0, my} * {31'd0, my}) +
                 ({31'd0, mz} * {31'd0, mz});
        r = '0;
        if (sum_sq == 0) begin
            r.zero_vector = 1'b1;
            return r;
        end
        q = unit_part(mx, sum_sq);
        r.unit_x = v.comp_x[31] ? -q : q;
        q = unit_part(my, sum_sq);
        r.unit_y = v.comp_y[31] ? -q : q;
        q = unit_part(mz, sum_sq);
        r.unit_z = v.comp_z[31] ? -q : q;
        r.length = 32'(floor_root({64'd0, sum_sq}));
        return r;
    endfunction

    function automatic vnu_pkg::in_t mk_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vnu_pkg::in_t v;
        v.comp_x = x;
        v.comp_y = y;
        v.comp_z = z;
        return v;
    endfunction

    function automatic vnu_pkg::out_t mk_res(logic [31:0] ux, logic [31:0] uy,
                                             logic [31:0] uz, logic [31:0] len, logic zv);
        vnu_pkg::out_t r;
        r.unit_x = ux;
        r.unit_y = uy;
        r.unit_z = uz;
        r.length = len;
        r.zero_vector = zv;
        return r;
    endfunction

    task automatic add_row(vnu_pkg::in_t v, logic known, vnu_pkg::out_t res);
        vec_row_t row;
        row.vec = v;
        row.known = known;
        row.res = res;
        vec_table.push_back(row);
    endtask

    // directed rows: zero vector, unit axes, extremes, most negative component
    task automatic build_table();
        localparam logic [31:0] ONE  = 32'h0001_0000;
        localparam logic [31:0] UNIT = 32'h4000_0000;
        localparam logic [31:0] MAXP = 32'h7fff_ffff;
        localparam logic [31:0] MINN = 32'h8000_0000;
        add_row(mk_vec(0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1'b1));
        add_row(mk_vec(ONE, 0, 0), 1'b1, mk_res(UNIT, 0, 0, ONE, 1'b0));
        add_row(mk_vec(0, -ONE, 0), 1'b1, mk_res(0, -UNIT, 0, ONE, 1'b0));
        add_row(mk_vec(0, 0, ONE), 1'b1, mk_res(0, 0, UNIT, ONE, 1'b0));
        add_row(mk_vec(MINN, 0, 0), 1'b1, mk_res(-UNIT, 0, 0, MINN, 1'b0));
        add_row(mk_vec(0, MINN, 0), 1'b1, mk_res(0, -UNIT, 0, MINN, 1'b0));
        add_row(mk_vec(0, 0, 1), 1'b1, mk_res(0, 0, UNIT, 1, 1'b0));
        add_row(mk_vec(MAXP, 0, 0), 1'b1, mk_res(UNIT, 0, 0, MAXP, 1'b0));
        add_row(mk_vec(MINN, MINN, MINN), 1'b0, '0);
        add_row(mk_vec(MAXP, MAXP, MAXP), 1'b0, '0);
        add_row(mk_vec(MAXP, MINN, MAXP), 1'b0, '0);
        add_row(mk_vec(1, 1, 1), 1'b0, '0);
        add_row(mk_vec(-1, 1, -1), 1'b0, '0);
        add_row(mk_vec(3 * ONE, 4 * ONE, 0), 1'b0, '0);
        add_row(mk_vec(MINN, 1, 0), 1'b0, '0);
        add_row(mk_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 1'b0, '0);
        add_row(mk_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f), 1'b0, '0);
        add_row(mk_vec(0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1'b1));
    endtask

    // random vector: mixes full-range, small, extreme, right-shifted and zero components
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($signed($urandom_range(0, 4096)) - 2048);
            2: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff);
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // drive one request and hold it until accepted; burst gaps before it
    task automatic send_vec(vnu_pkg::in_t v, int gap);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge
    endtask

    int burst_left = 0;

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 40);
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    // sender
    initial begin
        vnu_pkg::in_t v;
        build_table();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (vec_table[i]) begin
            // known rows also cross-check the predictor
            if (vec_table[i].known) begin
                pending_units.push_back(vec_table[i].res);
                if (normalize_vec(vec_table[i].vec) != vec_table[i].res) begin
                    $error("predictor disagrees with table row %0d", i);
                    errors++;
                end
            end else begin
                pending_units.push_back(normalize_vec(vec_table[i].vec));
            end
            send_vec(vec_table[i].vec, next_gap());
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            v = mk_vec(rand_comp(), rand_comp(), rand_comp());
            pending_units.push_back(normalize_vec(v));
            send_vec(v, next_gap());
        end
        s_valid <= 1'b0;
        feed_done <= 1'b1;
    end

    // receiver stall pattern: rotating phases of always-ready, random stalls and a periodic stall pattern
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if ((cycle / 500) % 3 == 0) m_ready <= 1'b1;
        else if ((cycle / 500) % 3 == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= (cycle[4:0] < 5'd12);
    end

    // result checker
    always @(posedge aclk) begin
        vnu_pkg::out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_units.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = pending_units.pop_front();
                results_seen++;
                if (e.zero_vector) zero_seen++;
                if (m_data.unit_x !== e.unit_x) begin
                    $error("unit_x expected %h got %h", e.unit_x, m_data.unit_x);
                    errors++;
                end
                if (m_data.unit_y !== e.unit_y) begin
                    $error("unit_y expected %h got %h", e.unit_y, m_data.unit_y);
                    errors++;
                end
                if (m_data.unit_z !== e.unit_z) begin
                    $error("unit_z expected %h got %h", e.unit_z, m_data.unit_z);
                    errors++;
                end
                if (m_data.length !== e.length) begin
                    $error("length expected %h got %h", e.length, m_data.length);
                    errors++;
                end
                if (m_data.zero_vector !== e.zero_vector) begin
                    $error("zero_vector expected %b got %b", e.zero_vector,
                           m_data.zero_vector);
                    errors++;
                end
            end
        end
    end

    // end of run: drain, wait past LATENCY so stray results show, then report
    initial begin
        wait (feed_done && pending_units.size() == 0);
        repeat (LATENCY + 8) @(posedge aclk);
        $display("covered %0d vectors, %0d of them zero, with bursty input and stalls",
                 results_seen, zero_seen);
        if (errors == 0 && pending_units.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        wait (cycle >= MAX_CYCLE);
        $display("timeout after %0d cycles", cycle);
        $display("tb_top failed");
        $finish;
    end

endmodule

### vec3_normalize_unit.f
sv/vnu_pkg.sv
sv/vnu_isqrt.sv
sv/vnu_div.sv
sv/vec3_normalize_unit.sv
verif/tb_top.sv
